>>> hdl/assert_macros.svh
// Assertion macros used by the port-level checker of the update unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define NMU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define NMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/nmu_pkg.sv
// Shared constants, types and a helper function of the Nesterov momentum update unit.
package nmu_pkg;

	localparam int NUM_PARAMS = 1024;
	localparam int MEM_AW     = $clog2(NUM_PARAMS);
	localparam int CLR_W      = MEM_AW + 1;
	localparam int IDX_W      = 10;
	localparam int VAL_W      = 32;
	localparam int RATE_W     = 16;
	localparam int RATE_SHIFT = 16;
	localparam int RND_HALF   = 1 << (RATE_SHIFT - 1);
	localparam int PROD_W     = VAL_W + RATE_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int TERM_W     = PROD_W + 2;
	localparam int WIDE_W     = 40;
	localparam int OUTQ_DEPTH = 8;
	localparam int QAW        = $clog2(OUTQ_DEPTH);
	localparam int LVL_W      = $clog2(OUTQ_DEPTH + 1);
	localparam int CNT_W      = LVL_W + 1;
	localparam int PADDR_W    = 4;
	localparam int DATA_W     = 32;

	typedef logic [RATE_W-1:0]        rate_t;
	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [LVL_W-1:0]         lvl_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic [PADDR_W-3:0] {
		REG_LR  = 2'd0,
		REG_MOM = 2'd1,
		REG_WD  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		rate_t step_rate;
		rate_t momentum;
		rate_t decay_rate;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] param_index;
		val_t             gradient;
		val_t             param_value;
		logic             reg_mask;
		logic             last_in;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		val_t             new_param;
		val_t             new_velocity;
		logic             last_out;
	} out_item_t;

	typedef struct packed {
		lvl_t level;
	} outq_stat_t;

	// Clamps a wide signed value to the 32-bit signed range.
	function automatic val_t sat_val(input wide_t x);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &x[WIDE_W-1:VAL_W-1];
		hi_zeros = ~|x[WIDE_W-1:VAL_W-1];
		if (hi_ones || hi_zeros)
			return x[VAL_W-1:0];
		else if (x[WIDE_W-1])
			return {1'b1, {(VAL_W-1){1'b0}}};
		else
			return {1'b0, {(VAL_W-1){1'b1}}};
	endfunction

endpackage

>>> hdl/nmu_if.sv
// Stream interfaces for parameter items and update result items.
interface nmu_in_if;
	logic                      valid;
	logic                      ready;
	logic [nmu_pkg::IDX_W-1:0] param_index;
	nmu_pkg::val_t             gradient;
	nmu_pkg::val_t             param_value;
	logic                      reg_mask;
	logic                      last_in;

	modport source (output valid, param_index, gradient, param_value, reg_mask, last_in,
		input ready);
	modport sink (input valid, param_index, gradient, param_value, reg_mask, last_in,
		output ready);
endinterface

interface nmu_out_if;
	logic                      valid;
	logic                      ready;
	logic [nmu_pkg::IDX_W-1:0] out_index;
	nmu_pkg::val_t             new_param;
	nmu_pkg::val_t             new_velocity;
	logic                      last_out;

	modport source (output valid, out_index, new_param, new_velocity, last_out,
		input ready);
	modport sink (input valid, out_index, new_param, new_velocity, last_out,
		output ready);
endinterface

>>> hdl/nesterov_momentum_param_update_unit.sv
// Top level of the Nesterov momentum parameter update unit.
//
// Channel   Kind        Direction  Contents
// params    valid/ready in         param_index, gradient, param_value, reg_mask, last_in
// results   valid/ready out        out_index, new_param, new_velocity, last_out
// apb       APB         in/out     step_rate @0x0, momentum @0x4, decay_rate @0x8
//
// One item per cycle while params.ready is high; each item passes through the pipeline before its
// result enters an eight-entry result queue. A new item whose parameter index matches one of
// the two items ahead of it waits until that item has written its velocity back.
// After reset all 1024 velocity memory entries are cleared; no item is taken until then.
// The queue gives the result side room to stall without stalling the pipeline.
module nesterov_momentum_param_update_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	nmu_in_if.sink                      params,
	nmu_out_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nmu_pkg::PADDR_W-1:0] paddr,
	input  logic [nmu_pkg::DATA_W-1:0]  pwdata,
	output logic [nmu_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	nmu_pkg::cfg_t       cfg;
	nmu_pkg::in_item_t   in_item;
	nmu_pkg::out_item_t  push_item;
	nmu_pkg::outq_stat_t q_stat;
	logic                push;

	assign in_item.param_index = params.param_index;
	assign in_item.gradient    = params.gradient;
	assign in_item.param_value = params.param_value;
	assign in_item.reg_mask    = params.reg_mask;
	assign in_item.last_in     = params.last_in;

	nmu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nmu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (params.valid),
		.in_item   (in_item),
		.in_ready  (params.ready),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	nmu_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.q_stat    (q_stat),
		.results   (results)
	);

endmodule

>>> hdl/nmu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nmu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/nmu_cfg.sv
// APB register file holding the learning rate, momentum and weight decay.
module nmu_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nmu_pkg::PADDR_W-1:0] paddr,
	input  logic [nmu_pkg::DATA_W-1:0]  pwdata,
	output logic [nmu_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output nmu_pkg::cfg_t               cfg
);

	nmu_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_rate  <= nmu_pkg::rate_t'(655);
			cfg_q.momentum   <= nmu_pkg::rate_t'(58982);
			cfg_q.decay_rate <= '0;
		end else if (wr_en) begin
			case (paddr[nmu_pkg::PADDR_W-1:2])
				nmu_pkg::REG_LR:  cfg_q.step_rate  <= pwdata[nmu_pkg::RATE_W-1:0];
				nmu_pkg::REG_MOM: cfg_q.momentum   <= pwdata[nmu_pkg::RATE_W-1:0];
				nmu_pkg::REG_WD:  cfg_q.decay_rate <= pwdata[nmu_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[nmu_pkg::PADDR_W-1:2])
			nmu_pkg::REG_LR:  prdata = nmu_pkg::DATA_W'(cfg_q.step_rate);
			nmu_pkg::REG_MOM: prdata = nmu_pkg::DATA_W'(cfg_q.momentum);
			nmu_pkg::REG_WD:  prdata = nmu_pkg::DATA_W'(cfg_q.decay_rate);
			default:          prdata = '0;
		endcase
	end

endmodule

>>> hdl/nmu_core.sv
// Update pipeline: velocity memory read, momentum arithmetic and write-back.
module nmu_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nmu_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	input  nmu_pkg::in_item_t    in_item,
	output logic                 in_ready,
	input  nmu_pkg::outq_stat_t  q_stat,
	output logic                 push,
	output nmu_pkg::out_item_t   push_item
);

	logic [nmu_pkg::CLR_W-1:0]  clr_q;
	logic                       clearing;
	logic                       fire;
	logic                       hit;
	logic [nmu_pkg::MEM_AW-1:0] in_slot;
	nmu_pkg::cnt_t              total;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [nmu_pkg::IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic                      last_s1, last_s2, last_s3, last_s4, last_s5;
	nmu_pkg::val_t             g_s1;
	nmu_pkg::val_t             p_s1, p_s2, p_s3, p_s4, p_s5;
	logic                      mask_s1;
	nmu_pkg::prod_t            lr_g_s2, momv_s2, wdp_s2;
	nmu_pkg::val_t             vn_s3, vn_s4, vn_s5;
	nmu_pkg::sum_t             pre_s3, pre_s4;
	nmu_pkg::prod_t            momvn_s4;
	logic signed [nmu_pkg::TERM_W-nmu_pkg::RATE_SHIFT-1:0] tr_s5;

	logic [nmu_pkg::VAL_W-1:0] rd_data;
	nmu_pkg::prod_t            lr_g_d, momv_d, wdp_d;
	nmu_pkg::sum_t             sum_v;
	logic signed [nmu_pkg::SUM_W-nmu_pkg::RATE_SHIFT-1:0] vr;
	nmu_pkg::val_t             vn_d;
	nmu_pkg::term_t            sum_t_d;
	nmu_pkg::wide_t            pn_wide;

	logic                       mem_we;
	logic [nmu_pkg::MEM_AW-1:0] mem_waddr;
	logic [nmu_pkg::VAL_W-1:0]  mem_wdata;

	assign clearing = (clr_q != nmu_pkg::CLR_W'(nmu_pkg::NUM_PARAMS));
	assign in_slot  = in_item.param_index[nmu_pkg::MEM_AW-1:0];
	assign hit      = (v_s1 && idx_s1[nmu_pkg::MEM_AW-1:0] == in_slot) ||
		(v_s2 && idx_s2[nmu_pkg::MEM_AW-1:0] == in_slot);
	assign total    = nmu_pkg::cnt_t'(q_stat.level) + nmu_pkg::cnt_t'(v_s1) +
		nmu_pkg::cnt_t'(v_s2) + nmu_pkg::cnt_t'(v_s3) + nmu_pkg::cnt_t'(v_s4) +
		nmu_pkg::cnt_t'(v_s5);
	assign in_ready = !clearing && !hit && (total < nmu_pkg::cnt_t'(nmu_pkg::OUTQ_DEPTH));
	assign fire     = in_valid && in_ready;

	assign mem_we    = clearing || v_s2;
	assign mem_waddr = clearing ? clr_q[nmu_pkg::MEM_AW-1:0] : idx_s2[nmu_pkg::MEM_AW-1:0];
	assign mem_wdata = clearing ? '0 : vn_d;

	nmu_ram #(
		.WIDTH (nmu_pkg::VAL_W),
		.DEPTH (nmu_pkg::NUM_PARAMS)
	) u_vel_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (fire),
		.raddr (in_slot),
		.rdata (rd_data)
	);

	assign lr_g_d = nmu_pkg::prod_t'({1'b0, cfg.step_rate}) * nmu_pkg::prod_t'(g_s1);
	assign momv_d = nmu_pkg::prod_t'({1'b0, cfg.momentum}) *
		nmu_pkg::prod_t'(nmu_pkg::val_t'(rd_data));
	assign wdp_d  = mask_s1 ?
		nmu_pkg::prod_t'({1'b0, cfg.decay_rate}) * nmu_pkg::prod_t'(p_s1) : '0;

	assign sum_v = nmu_pkg::sum_t'(lr_g_s2) + nmu_pkg::sum_t'(momv_s2) +
		nmu_pkg::sum_t'(nmu_pkg::RND_HALF);
	assign vr    = sum_v[nmu_pkg::SUM_W-1:nmu_pkg::RATE_SHIFT];
	assign vn_d  = nmu_pkg::sat_val(nmu_pkg::wide_t'(vr));

	assign sum_t_d = nmu_pkg::term_t'(momvn_s4) + nmu_pkg::term_t'(pre_s4) +
		nmu_pkg::term_t'(nmu_pkg::RND_HALF);
	assign pn_wide = nmu_pkg::wide_t'(p_s5) - nmu_pkg::wide_t'(tr_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
		end else begin
			if (clearing)
				clr_q <= clr_q + nmu_pkg::CLR_W'(1);
			v_s1 <= fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= in_item.param_index;
		g_s1     <= in_item.gradient;
		p_s1     <= in_item.param_value;
		mask_s1  <= in_item.reg_mask;
		last_s1  <= in_item.last_in;

		idx_s2   <= idx_s1;
		p_s2     <= p_s1;
		last_s2  <= last_s1;
		lr_g_s2  <= lr_g_d;
		momv_s2  <= momv_d;
		wdp_s2   <= wdp_d;

		idx_s3   <= idx_s2;
		p_s3     <= p_s2;
		last_s3  <= last_s2;
		vn_s3    <= vn_d;
		pre_s3   <= nmu_pkg::sum_t'(wdp_s2) - nmu_pkg::sum_t'(lr_g_s2);

		idx_s4   <= idx_s3;
		p_s4     <= p_s3;
		last_s4  <= last_s3;
		vn_s4    <= vn_s3;
		pre_s4   <= pre_s3;
		momvn_s4 <= nmu_pkg::prod_t'({1'b0, cfg.momentum}) * nmu_pkg::prod_t'(vn_s3);

		idx_s5   <= idx_s4;
		p_s5     <= p_s4;
		last_s5  <= last_s4;
		vn_s5    <= vn_s4;
		tr_s5    <= sum_t_d[nmu_pkg::TERM_W-1:nmu_pkg::RATE_SHIFT];
	end

	assign push                   = v_s5;
	assign push_item.out_index    = idx_s5;
	assign push_item.new_param    = nmu_pkg::sat_val(pn_wide);
	assign push_item.new_velocity = vn_s5;
	assign push_item.last_out     = last_s5;

endmodule

>>> hdl/nmu_outq.sv
// Result queue that decouples the update pipeline from the result channel.
module nmu_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  nmu_pkg::out_item_t  push_item,
	output nmu_pkg::outq_stat_t q_stat,
	nmu_out_if.source           results
);

	nmu_pkg::out_item_t      buf_q [nmu_pkg::OUTQ_DEPTH];
	logic [nmu_pkg::QAW-1:0] wr_ptr_q;
	logic [nmu_pkg::QAW-1:0] rd_ptr_q;
	nmu_pkg::lvl_t           level_q;
	logic                    pop;
	nmu_pkg::out_item_t      head;

	assign pop  = results.valid && results.ready;
	assign head = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + nmu_pkg::QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + nmu_pkg::QAW'(1);
			level_q <= level_q + nmu_pkg::lvl_t'(push) - nmu_pkg::lvl_t'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= push_item;
	end

	assign q_stat.level         = level_q;
	assign results.valid        = (level_q != '0);
	assign results.out_index    = head.out_index;
	assign results.new_param    = head.new_param;
	assign results.new_velocity = head.new_velocity;
	assign results.last_out     = head.last_out;

endmodule

>>> hdl/nmu_checker.sv
// Port-level checker for the update unit and its bind to the top level.
`include "assert_macros.svh"

module nmu_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [nmu_pkg::DATA_W-1:0] prdata
);

	logic [nmu_pkg::CNT_W-1:0] pend_q;
	logic                      in_fire;
	logic                      out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + nmu_pkg::CNT_W'(in_fire) - nmu_pkg::CNT_W'(out_fire);
	end

	`NMU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result item dropped while stalled")
	`NMU_ASSERT(a_no_phantom, clk, arst_n, !out_valid || pend_q != '0, "result item without a pending input item")
	`NMU_ASSERT(a_credit, clk, arst_n, pend_q <= nmu_pkg::CNT_W'(nmu_pkg::OUTQ_DEPTH), "more items in flight than queue entries")
	`NMU_ASSERT(a_rdata_hi, clk, arst_n, prdata[nmu_pkg::DATA_W-1:nmu_pkg::RATE_W] == '0, "register read returned bits above the rate field")

endmodule

bind nesterov_momentum_param_update_unit nmu_checker u_nmu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (params.valid),
	.in_ready  (params.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.prdata    (prdata)
);

>>> bench/tb_nesterov_momentum_param_update_unit.sv
// Self-checking testbench of the Nesterov momentum parameter update unit.
`timescale 1ns / 100ps

module tb_nesterov_momentum_param_update_unit;

	localparam int     STALL_LIMIT  = 5000;
	localparam int     HOLD_CYCLES  = 400;
	localparam int     DRAIN_CYCLES = 20;
	localparam int     PHASE_ITEMS  = 68;
	localparam int     NUM_PHASES   = 8;
	localparam int     MAX_REPORTS  = 10;
	localparam logic [nmu_pkg::PADDR_W-3:0] REG_SPARE = 2'd3;
	localparam longint VAL_MAX      = 64'sd2147483647;
	localparam longint VAL_MIN      = -64'sd2147483647 - 64'sd1;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [nmu_pkg::PADDR_W-1:0] paddr;
	logic [nmu_pkg::DATA_W-1:0]  pwdata;
	logic [nmu_pkg::DATA_W-1:0]  prdata;
	logic                        pready;

	nmu_in_if  param_ch ();
	nmu_out_if result_ch ();

	nesterov_momentum_param_update_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.params  (param_ch),
		.results (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	nmu_pkg::cfg_t      cfg = '{step_rate: 16'd655, momentum: 16'd58982, decay_rate: 16'd0};
	nmu_pkg::val_t      velocity_mem [nmu_pkg::NUM_PARAMS];
	nmu_pkg::in_item_t  param_queue [$];
	nmu_pkg::out_item_t pending_results [$];
	int                 mismatch_count = 0;
	int                 src_idle_pct   = 0;
	int                 sink_idle_pct  = 0;
	int                 stall_cycles   = 0;
	int                 hold_left      = 0;
	int                 hold_req       = 0;
	int                 hold_ack       = 0;

	initial begin
		foreach (velocity_mem[i])
			velocity_mem[i] = '0;
	end

	always #10 clk = ~clk;

	function automatic longint round_q16(longint x);
		return (x + longint'(nmu_pkg::RND_HALF)) >>> nmu_pkg::RATE_SHIFT;
	endfunction

	function automatic nmu_pkg::val_t clamp32(longint x);
		if (x > VAL_MAX)
			return nmu_pkg::val_t'(VAL_MAX);
		if (x < VAL_MIN)
			return nmu_pkg::val_t'(VAL_MIN);
		return nmu_pkg::val_t'(x);
	endfunction

	function automatic nmu_pkg::out_item_t predict_update(nmu_pkg::in_item_t it);
		longint             lr;
		longint             mom;
		longint             wd;
		longint             g;
		longint             p;
		longint             v;
		longint             lr_g;
		longint             term;
		nmu_pkg::val_t      v_new;
		nmu_pkg::out_item_t r;
		lr    = longint'(cfg.step_rate);
		mom   = longint'(cfg.momentum);
		wd    = longint'(cfg.decay_rate);
		g     = longint'(it.gradient);
		p     = longint'(it.param_value);
		v     = longint'(velocity_mem[it.param_index]);
		lr_g  = lr * g;
		v_new = clamp32(round_q16(lr_g + mom * v));
		velocity_mem[it.param_index] = v_new;
		term  = mom * longint'(v_new) - lr_g;
		if (it.reg_mask && wd != 0)
			term += wd * p;
		r.out_index    = it.param_index;
		r.new_param    = clamp32(p - round_q16(term));
		r.new_velocity = v_new;
		r.last_out     = it.last_in;
		return r;
	endfunction

	task automatic queue_param(input logic [nmu_pkg::IDX_W-1:0] idx, input logic [31:0] g,
		input logic [31:0] p, input logic mask, input logic last);
		param_queue.push_back('{param_index: idx, gradient: g, param_value: p,
			reg_mask: mask, last_in: last});
	endtask

	task automatic write_reg(input logic [nmu_pkg::PADDR_W-3:0] idx,
		input logic [nmu_pkg::DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			nmu_pkg::REG_LR:  cfg.step_rate  = value[nmu_pkg::RATE_W-1:0];
			nmu_pkg::REG_MOM: cfg.momentum   = value[nmu_pkg::RATE_W-1:0];
			nmu_pkg::REG_WD:  cfg.decay_rate = value[nmu_pkg::RATE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (param_queue.size() != 0 || param_ch.valid || pending_results.size() != 0);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			param_ch.valid <= 1'b0;
		end else begin
			if (param_ch.valid && param_ch.ready)
				pending_results.push_back(predict_update('{
					param_index: param_ch.param_index, gradient: param_ch.gradient,
					param_value: param_ch.param_value, reg_mask: param_ch.reg_mask,
					last_in: param_ch.last_in}));
			if (!param_ch.valid || param_ch.ready) begin
				if (param_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					param_ch.param_index <= param_queue[0].param_index;
					param_ch.gradient    <= param_queue[0].gradient;
					param_ch.param_value <= param_queue[0].param_value;
					param_ch.reg_mask    <= param_queue[0].reg_mask;
					param_ch.last_in     <= param_queue[0].last_in;
					param_ch.valid       <= 1'b1;
					void'(param_queue.pop_front());
				end else begin
					param_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left       <= hold_left - 1;
		end else if (hold_ack != hold_req) begin
			result_ch.ready <= 1'b0;
			hold_ack        <= hold_req;
			hold_left       <= HOLD_CYCLES;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		nmu_pkg::out_item_t got;
		nmu_pkg::out_item_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{out_index: result_ch.out_index, new_param: result_ch.new_param,
				new_velocity: result_ch.new_velocity, last_out: result_ch.last_out};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: index %0d param %0d velocity %0d last %0b",
						got.out_index, got.new_param, got.new_velocity, got.last_out);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: expected index %0d param %0d velocity %0d last %0b,",
							want.out_index, want.new_param, want.new_velocity, want.last_out,
							" got index %0d param %0d velocity %0d last %0b",
							got.out_index, got.new_param, got.new_velocity, got.last_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((param_ch.valid && param_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_nesterov_momentum_param_update_unit failed");
			$finish;
		end
	end

	initial begin
		nmu_pkg::in_item_t it;
		clk                   = 1'b0;
		arst_n                = 1'b0;
		psel                  = 1'b0;
		penable               = 1'b0;
		pwrite                = 1'b0;
		paddr                 = '0;
		pwdata                = '0;
		param_ch.valid        = 1'b0;
		param_ch.param_index  = '0;
		param_ch.gradient     = '0;
		param_ch.param_value  = '0;
		param_ch.reg_mask     = 1'b0;
		param_ch.last_in      = 1'b0;
		result_ch.ready       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset rates; decay is off, so the mask must not matter.
		queue_param(10'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
		queue_param(10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
		queue_param(10'd1023, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
		queue_param(10'd1023, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
		queue_param(10'd5, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0);
		queue_param(10'd5, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b0);
		queue_param(10'd6, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1);
		queue_param(10'd5, 32'hFFFF_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
		wait_drained();

		// Full-scale rates; upper bits of the written words must be dropped.
		write_reg(nmu_pkg::REG_LR, 32'hFFFF_FFFF);
		write_reg(nmu_pkg::REG_MOM, 32'hA5A5_FFFF);
		write_reg(nmu_pkg::REG_WD, 32'h0001_FFFF);
		write_reg(REG_SPARE, 32'h0000_1234);
		queue_param(10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
		queue_param(10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
		queue_param(10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
		queue_param(10'd0, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
		queue_param(10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1);
		queue_param(10'd2, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b1);
		queue_param(10'd2, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
		queue_param(10'd3, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b1);
		queue_param(10'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
		wait_drained();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == 0) begin
				write_reg(nmu_pkg::REG_LR, 32'h0);
				write_reg(nmu_pkg::REG_MOM, 32'h0);
				write_reg(nmu_pkg::REG_WD, 32'h0);
			end else if (ph == 1) begin
				write_reg(nmu_pkg::REG_LR, 32'hFFFF);
				write_reg(nmu_pkg::REG_MOM, 32'h0);
				write_reg(nmu_pkg::REG_WD, 32'h1);
			end else begin
				write_reg(nmu_pkg::REG_LR, $urandom());
				write_reg(nmu_pkg::REG_MOM, $urandom());
				write_reg(nmu_pkg::REG_WD, ($urandom_range(3) == 0) ? 32'h0 : $urandom());
			end
			write_reg(REG_SPARE, $urandom());
			case (ph % 4)
				0: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
				1: begin src_idle_pct = 60; sink_idle_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_idle_pct = 60; end
				default: begin src_idle_pct = 17; sink_idle_pct = 17; end
			endcase
			if (ph == 4)
				hold_req++;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				it.param_index = $urandom_range(1) ? nmu_pkg::IDX_W'($urandom_range(7)) :
					nmu_pkg::IDX_W'($urandom());
				case ($urandom_range(3))
					1: it.gradient = $signed($urandom_range(262143)) - 131072;
					2: it.gradient = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					default: it.gradient = $urandom();
				endcase
				case ($urandom_range(3))
					1: it.param_value = $signed($urandom_range(262143)) - 131072;
					2: it.param_value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					default: it.param_value = $urandom();
				endcase
				it.reg_mask = 1'($urandom_range(1));
				it.last_in  = 1'($urandom_range(1));
				param_queue.push_back(it);
			end
			wait_drained();
		end

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_nesterov_momentum_param_update_unit passed");
		else
			$display("tb_nesterov_momentum_param_update_unit failed");
		$finish;
	end

endmodule
